/* sv/x86a_pkg.sv */
// Shared types, opcode codes and EFLAGS bit positions for the x86 ALU.
`default_nettype none

package x86a_pkg;

    // Opcode codes
    localparam logic [4:0] OP_TEST = 5'd0;
    localparam logic [4:0] OP_CMP  = 5'd1;
    localparam logic [4:0] OP_AND  = 5'd2;
    localparam logic [4:0] OP_OR   = 5'd3;
    localparam logic [4:0] OP_XOR  = 5'd4;
    localparam logic [4:0] OP_ADD  = 5'd5;
    localparam logic [4:0] OP_SUB  = 5'd6;
    localparam logic [4:0] OP_ADC  = 5'd7;
    localparam logic [4:0] OP_SBB  = 5'd8;
    localparam logic [4:0] OP_BT   = 5'd9;
    localparam logic [4:0] OP_BTS  = 5'd10;
    localparam logic [4:0] OP_BTR  = 5'd11;
    localparam logic [4:0] OP_BTC  = 5'd12;
    localparam logic [4:0] OP_INC  = 5'd13;
    localparam logic [4:0] OP_DEC  = 5'd14;
    localparam logic [4:0] OP_NOT  = 5'd15;
    localparam logic [4:0] OP_NEG  = 5'd16;
    localparam logic [4:0] OP_MOV  = 5'd17;
    localparam logic [4:0] OP_SHL  = 5'd18;
    localparam logic [4:0] OP_SHR  = 5'd19;
    localparam logic [4:0] OP_SAR  = 5'd20;

    // Operand size codes
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_WORD = 2'd1;

    // EFLAGS status bit positions
    localparam int CF_BIT = 0;
    localparam int PF_BIT = 2;
    localparam int AF_BIT = 4;
    localparam int ZF_BIT = 6;
    localparam int SF_BIT = 7;
    localparam int OF_BIT = 11;

    localparam logic [31:0] STATUS_BITS = 32'h0000_08D5;

    typedef struct packed {
        logic [4:0]  opcode;
        logic [1:0]  size_code;
        logic        mem_is_dest;
        logic [31:0] mem_value;
        logic [31:0] other_value;
        logic [31:0] flags_in;
    } alu_in_t;

    typedef struct packed {
        logic [31:0] result_value;
        logic        write_mem;
        logic        write_gpr;
        logic [31:0] flags_out;
    } alu_out_t;

endpackage

`default_nettype wire

/* sv/x86a_core.sv */
// Combinational datapath of the x86 ALU: result, write targets and EFLAGS.
`default_nettype none

module x86a_core (
    input  wire x86a_pkg::alu_in_t  op,
    output x86a_pkg::alu_out_t res
);
    import x86a_pkg::*;

    // Pick the sign bit for the operand size
    function automatic logic msb_of(input logic [31:0] v, input logic [1:0] sc);
        logic m;
        case (sc)
            SIZE_BYTE: m = v[7];
            SIZE_WORD: m = v[15];
            default:   m = v[31];
        endcase
        return m;
    endfunction

    // ZF, SF and PF of a masked result
    function automatic logic [31:0] zsp_of(input logic [31:0] r, input logic [1:0] sc);
        logic [31:0] f;
        f = '0;
        f[ZF_BIT] = (r == 32'd0);
        f[SF_BIT] = msb_of(r, sc);
        f[PF_BIT] = ~^r[7:0];
        return f;
    endfunction

    logic [31:0] mask;
    logic [5:0]  width;
    logic [4:0]  bit_mask;
    logic [31:0] mv;
    logic [31:0] ov;
    logic [31:0] a;
    logic [31:0] b;
    logic        cin;

    // Size-dependent masks
    always_comb
    begin
        case (op.size_code)
            SIZE_BYTE:
            begin
                mask     = 32'h0000_00FF;
                width    = 6'd8;
                bit_mask = 5'd7;
            end
            SIZE_WORD:
            begin
                mask     = 32'h0000_FFFF;
                width    = 6'd16;
                bit_mask = 5'd15;
            end
            default:
            begin
                mask     = 32'hFFFF_FFFF;
                width    = 6'd32;
                bit_mask = 5'd31;
            end
        endcase
    end

    assign mv  = op.mem_value & mask;
    assign ov  = op.other_value & mask;
    assign a   = op.mem_is_dest ? mv : ov;
    assign b   = op.mem_is_dest ? ov : mv;
    assign cin = op.flags_in[CF_BIT];

    // Shared adder and subtractor operand selection
    logic [31:0] add_x;
    logic [31:0] add_y;
    logic        add_c;
    logic [31:0] sub_x;
    logic [31:0] sub_y;
    logic        sub_c;

    always_comb
    begin
        add_x = a;
        add_y = b;
        add_c = (op.opcode == OP_ADC) ? cin : 1'b0;
        if (op.opcode == OP_INC)
        begin
            add_x = mv;
            add_y = 32'd1;
            add_c = 1'b0;
        end
        sub_x = a;
        sub_y = b;
        sub_c = (op.opcode == OP_SBB) ? cin : 1'b0;
        if (op.opcode == OP_DEC)
        begin
            sub_x = mv;
            sub_y = 32'd1;
            sub_c = 1'b0;
        end
        else if (op.opcode == OP_NEG)
        begin
            sub_x = 32'd0;
            sub_y = mv;
            sub_c = 1'b0;
        end
    end

    // Add with carry-out at the operand size
    logic [32:0] sum;
    logic [31:0] add_r;
    logic [31:0] add_f;
    logic        add_carry;

    assign sum   = {1'b0, add_x} + {1'b0, add_y} + {32'd0, add_c};
    assign add_r = sum[31:0] & mask;

    always_comb
    begin
        case (op.size_code)
            SIZE_BYTE: add_carry = sum[8];
            SIZE_WORD: add_carry = sum[16];
            default:   add_carry = sum[32];
        endcase
        add_f         = zsp_of(add_r, op.size_code);
        add_f[CF_BIT] = add_carry;
        add_f[OF_BIT] = msb_of(~(add_x ^ add_y) & (add_x ^ add_r), op.size_code);
        add_f[AF_BIT] = add_x[4] ^ add_y[4] ^ add_r[4];
    end

    // Subtract with borrow; operands are masked so bit 32 is the borrow
    logic [32:0] dif;
    logic [31:0] sub_r;
    logic [31:0] sub_f;

    assign dif   = {1'b0, sub_x} - {1'b0, sub_y} - {32'd0, sub_c};
    assign sub_r = dif[31:0] & mask;

    always_comb
    begin
        sub_f         = zsp_of(sub_r, op.size_code);
        sub_f[CF_BIT] = dif[32];
        sub_f[OF_BIT] = msb_of((sub_x ^ sub_y) & (sub_x ^ sub_r), op.size_code);
        sub_f[AF_BIT] = sub_x[4] ^ sub_y[4] ^ sub_r[4];
    end

    // Logical results
    logic [31:0] and_r;
    logic [31:0] or_r;
    logic [31:0] xor_r;

    assign and_r = mv & ov;
    assign or_r  = mv | ov;
    assign xor_r = mv ^ ov;

    // Bit test family
    logic [4:0]  bt_idx;
    logic [31:0] bt_bm;
    logic [31:0] bt_flags;

    assign bt_idx   = op.other_value[4:0] & bit_mask;
    assign bt_bm    = 32'd1 << bt_idx;
    assign bt_flags = {op.flags_in[31:1], mv[bt_idx]};

    // Shifts
    logic [4:0]  cnt;
    logic        cnt_in_range;
    logic [5:0]  shl_pos;
    logic [4:0]  shr_pos;
    logic [31:0] sar_x;
    logic [31:0] shl_r;
    logic [31:0] shr_r;
    logic [31:0] sar_r;
    logic        shl_cf;
    logic        shr_cf;

    assign cnt          = op.other_value[4:0];
    assign cnt_in_range = ({1'b0, cnt} <= width);
    assign shl_pos      = width - {1'b0, cnt};
    assign shr_pos      = cnt - 5'd1;
    assign sar_x        = msb_of(mv, op.size_code) ? (mv | ~mask) : mv;
    assign shl_r        = (mv << cnt) & mask;
    assign shr_r        = (mv >> cnt) & mask;
    assign sar_r        = 32'($signed(sar_x) >>> cnt) & mask;
    assign shl_cf       = cnt_in_range & mv[shl_pos[4:0]];
    assign shr_cf       = cnt_in_range & mv[shr_pos];

    // Select result, targets and flags per opcode
    logic [31:0] r;
    logic [31:0] fl;
    logic        wm;
    logic        wr;
    logic        setf;
    logic        bt_op;

    always_comb
    begin
        r     = '0;
        fl    = '0;
        wm    = 1'b0;
        wr    = 1'b0;
        setf  = 1'b1;
        bt_op = 1'b0;
        case (op.opcode)
            OP_TEST:
            begin
                fl = zsp_of(and_r, op.size_code);
            end
            OP_CMP:
            begin
                fl = sub_f;
            end
            OP_AND, OP_OR, OP_XOR:
            begin
                r  = (op.opcode == OP_AND) ? and_r :
                     ((op.opcode == OP_OR) ? or_r : xor_r);
                fl = zsp_of(r, op.size_code);
                wm = op.mem_is_dest;
                wr = ~op.mem_is_dest;
            end
            OP_ADD, OP_ADC:
            begin
                r  = add_r;
                fl = add_f;
                wm = op.mem_is_dest;
                wr = ~op.mem_is_dest;
            end
            OP_SUB, OP_SBB:
            begin
                r  = sub_r;
                fl = sub_f;
                wm = op.mem_is_dest;
                wr = ~op.mem_is_dest;
            end
            OP_BT, OP_BTS, OP_BTR, OP_BTC:
            begin
                bt_op = 1'b1;
                fl    = bt_flags;
                if (op.opcode == OP_BTS)
                    r = mv | bt_bm;
                else if (op.opcode == OP_BTR)
                    r = mv & ~bt_bm;
                else if (op.opcode == OP_BTC)
                    r = mv ^ bt_bm;
                wm = (op.opcode != OP_BT);
            end
            OP_INC:
            begin
                r          = add_r;
                fl         = add_f;
                fl[CF_BIT] = cin;
                wm         = 1'b1;
            end
            OP_DEC:
            begin
                r          = sub_r;
                fl         = sub_f;
                fl[CF_BIT] = cin;
                wm         = 1'b1;
            end
            OP_NOT:
            begin
                r    = ~mv & mask;
                wm   = 1'b1;
                setf = 1'b0;
            end
            OP_NEG:
            begin
                r  = sub_r;
                fl = sub_f;
                wm = 1'b1;
            end
            OP_MOV:
            begin
                r    = op.mem_is_dest ? ov : mv;
                wm   = op.mem_is_dest;
                wr   = ~op.mem_is_dest;
                setf = 1'b0;
            end
            OP_SHL, OP_SHR, OP_SAR:
            begin
                if (cnt == 5'd0)
                begin
                    setf = 1'b0;
                end
                else
                begin
                    if (op.opcode == OP_SHL)
                        r = shl_r;
                    else if (op.opcode == OP_SHR)
                        r = shr_r;
                    else
                        r = sar_r;
                    fl         = zsp_of(r, op.size_code);
                    fl[CF_BIT] = (op.opcode == OP_SHL) ? shl_cf : shr_cf;
                    fl[OF_BIT] = (op.opcode == OP_SHL) && (cnt == 5'd1) &&
                                 (msb_of(r, op.size_code) ^ shl_cf);
                    wm         = 1'b1;
                end
            end
            default:
            begin
                setf = 1'b0;
            end
        endcase
    end

    // Merge status flags and drop the result when nothing is written
    always_comb
    begin
        if (!setf)
            res.flags_out = op.flags_in;
        else if (bt_op)
            res.flags_out = fl;
        else
            res.flags_out = (op.flags_in & ~STATUS_BITS) | (fl & STATUS_BITS);
        res.result_value = (wm | wr) ? (r & mask) : 32'd0;
        res.write_mem    = wm;
        res.write_gpr    = wr;
    end

endmodule

`default_nettype wire

/* sv/x86_alu_with_status_flags_top.sv */
// Top level of the x86 ALU: input register, ALU datapath and result register.
`default_nettype none

// Executes one x86 integer operation (logic, add/sub, bit test, inc/dec, not,
// neg, mov, shifts) on a 1, 2 or 4 byte operand and returns the masked result,
// its write target and the updated EFLAGS. One operation is taken per clock
// cycle while the result side is not stalled; each result passes through the
// input register and then the result register, with the single ALU pass
// between them. Both registers hold under back-pressure, so up to two
// operations may be in flight while the result side stalls.

module x86_alu_with_status_flags_top (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 op_valid,
    output logic                op_ready,
    input  wire x86a_pkg::alu_in_t op_data,
    output logic                res_valid,
    input  wire                 res_ready,
    output x86a_pkg::alu_out_t  res_data
);
    import x86a_pkg::*;

    logic      s1_valid_reg;
    alu_in_t   s1_data_reg;
    logic      res_valid_reg;
    alu_out_t  res_data_reg;
    alu_out_t  alu_res;
    logic      s1_adv;

    // Advance stage one when the result register is free or draining
    assign s1_adv   = ~res_valid_reg | res_ready;
    assign op_ready = ~s1_valid_reg | s1_adv;

    // Hold the operation in the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (op_ready)
            s1_valid_reg <= op_valid;
    end

    always_ff @(posedge clk)
    begin
        if (op_ready && op_valid)
            s1_data_reg <= op_data;
    end

    x86a_core u_core (
        .op  (s1_data_reg),
        .res (alu_res)
    );

    // Capture the ALU result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (s1_adv)
            res_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_valid_reg)
            res_data_reg <= alu_res;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // A result never goes to both memory and register
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> !(res_data_reg.write_mem && res_data_reg.write_gpr))
        else $error("result targets both memory and register");

    // No write means a zero result
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_data_reg.write_mem && !res_data_reg.write_gpr)
        |-> (res_data_reg.result_value == 32'd0))
        else $error("result value nonzero without a write");

    // Non-status EFLAGS bits pass through
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_valid_reg) |=>
        (((res_data_reg.flags_out ^ $past(s1_data_reg.flags_in)) & ~STATUS_BITS) == 32'd0))
        else $error("non-status flag bit changed");

    // Byte operations leave the upper result bits clear
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_valid_reg && s1_data_reg.size_code == SIZE_BYTE) |=>
        (res_data_reg.result_value[31:8] == 24'd0))
        else $error("byte result not masked");

endmodule

`default_nettype wire
